### src/blf_pkg.sv
package blf_pkg;

    localparam int NUM_W = 22;  // magnitude of (5*sample - adc_low) * 100
    localparam int DEN_W = 15;  // magnitude of the span
    localparam int PCT_W = 7;

    localparam logic [PCT_W-1:0] PCT_MAX    = 7'd100;
    localparam logic [PCT_W-1:0] LAST_RESET = 7'd101;
    localparam logic [PCT_W-1:0] LVL_LOW    = 7'd20;
    localparam logic [PCT_W-1:0] LVL_MID    = 7'd40;

    localparam logic [14:0] ADC_LOW_RST  = 15'd2400;
    localparam logic [14:0] ADC_HIGH_RST = 15'd4200;
    localparam logic [6:0]  OUTLIER_RST  = 7'd10;

    // register indexes
    localparam logic [1:0] REG_ADC_LOW  = 2'd0;
    localparam logic [1:0] REG_ADC_HIGH = 2'd1;
    localparam logic [1:0] REG_OUTLIER  = 2'd2;

    // mean divisor selects
    localparam logic [1:0] SEL_BURST = 2'd1;
    localparam logic [1:0] SEL_HIST  = 2'd2;

    // level classes
    localparam logic [1:0] CLS_CHARGING = 2'd0;
    localparam logic [1:0] CLS_LOW      = 2'd1;
    localparam logic [1:0] CLS_MID      = 2'd2;
    localparam logic [1:0] CLS_HIGH     = 2'd3;

    typedef struct packed {
        logic [11:0] raw_sample;
        logic        charging;
    } t_in;

    typedef struct packed {
        logic [6:0] level_percent;
        logic       level_changed;
        logic [1:0] level_class;
    } t_out;

    typedef struct packed {
        logic       load_in;
        logic       div_start;
        logic [1:0] div_sel;
        logic       wr_sample;
        logic       rd;
        logic       pass2;
        logic       mean_ld;
        logic       hist_shift;
        logic       hrot;
        logic       level_ld;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic burst_last;
        logic idx_last;
        logic hidx_last;
        logic out_free;
    } t_sts;

endpackage

### src/blf_div.sv
module blf_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [blf_pkg::NUM_W-1:0]   i_num,
    input  logic [blf_pkg::DEN_W-1:0]   i_den,
    output logic                        o_done,
    output logic [blf_pkg::NUM_W-1:0]   o_quo
);

    localparam int CNT_W = $clog2(blf_pkg::NUM_W + 1);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [blf_pkg::NUM_W-1:0]   r_quo;
    logic [blf_pkg::DEN_W-1:0]   r_rem;
    logic [blf_pkg::DEN_W-1:0]   r_den;
    logic [blf_pkg::DEN_W:0]     trial;
    logic                        ge;

    // one quotient bit a cycle, restoring
    assign trial = {r_rem, r_quo[blf_pkg::NUM_W-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(blf_pkg::NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[blf_pkg::NUM_W-2:0], ge};
            r_rem <= ge ? blf_pkg::DEN_W'(trial - {1'b0, r_den})
                        : trial[blf_pkg::DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

### src/blf_datapath.sv
module blf_datapath #(
    parameter int BURST_LEN   = 10,
    parameter int HISTORY_LEN = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  blf_pkg::t_cmd        i_cmd,
    output blf_pkg::t_sts        o_sts,
    input  blf_pkg::t_in         i_in_data,
    input  logic [14:0]          i_adc_low,
    input  logic [14:0]          i_adc_high,
    input  logic [6:0]           i_outlier_limit,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output blf_pkg::t_out        o_out_data
);

    localparam int MAXL   = (BURST_LEN > HISTORY_LEN) ? BURST_LEN : HISTORY_LEN;
    localparam int IDX_W  = $clog2(MAXL);
    localparam int BIDX_W = $clog2(BURST_LEN);
    localparam int SUM_W  = $clog2(100 * MAXL + 1);
    localparam int RSH    = 17;
    localparam int PRD_W  = SUM_W + RSH;
    // reciprocals rounded up; exact for any sum of up to 32 percent values
    localparam logic [RSH-1:0] RCP_B = RSH'((2 ** RSH + BURST_LEN - 1) / BURST_LEN);
    localparam logic [RSH-1:0] RCP_H = RSH'((2 ** RSH + HISTORY_LEN - 1) / HISTORY_LEN);

    logic [BIDX_W-1:0]          r_cnt;
    logic [IDX_W-1:0]           r_idx;
    logic [SUM_W-1:0]           r_sum;
    logic [14:0]                r_v;
    logic                       r_chg;
    logic [6:0]                 r_mean;
    logic [6:0]                 r_level;
    logic [6:0]                 r_last;
    logic                       r_use_hist;
    logic                       r_rd_v;
    logic [6:0]                 r_rdata;
    logic                       r_out_valid;
    blf_pkg::t_out              r_out;
    logic [6:0]                 mem [BURST_LEN];
    logic [6:0]                 r_hist [HISTORY_LEN];

    logic [15:0]                nd;
    logic [15:0]                dd;
    logic [14:0]                nmag;
    logic [14:0]                dmag;
    logic [blf_pkg::NUM_W-1:0]  pnum;
    logic [blf_pkg::NUM_W-1:0]  quo;
    logic                       div_done;
    logic [6:0]                 pct;
    logic [6:0]                 dev;
    logic [6:0]                 term;
    logic [1:0]                 cls;
    logic [RSH-1:0]             rcp;
    logic [PRD_W-1:0]           prod;
    logic [6:0]                 avg;

    // signed numerator and span, sign in bit 15
    assign nd   = {1'b0, r_v} - {1'b0, i_adc_low};
    assign dd   = {1'b0, i_adc_high} - {1'b0, i_adc_low};
    assign nmag = nd[15] ? 15'(-nd) : nd[14:0];
    assign dmag = dd[15] ? 15'(-dd) : dd[14:0];
    assign pnum = blf_pkg::NUM_W'(nmag) * blf_pkg::NUM_W'(100);

    blf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (pnum),
        .i_den   (dmag),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    // mean of the running sum by reciprocal multiplication
    assign rcp  = (i_cmd.div_sel == blf_pkg::SEL_HIST) ? RCP_H : RCP_B;
    assign prod = PRD_W'(r_sum) * PRD_W'(rcp);
    assign avg  = prod[RSH +: 7];

    // truncation toward zero: opposite signs give zero; equal span is a step; above 100 clamps to 100
    always_comb begin
        priority if (dd == '0) begin
            pct = (r_v >= i_adc_low) ? blf_pkg::PCT_MAX : '0;
        end else if (nd == '0 || (nd[15] ^ dd[15])) begin
            pct = '0;
        end else if (quo > blf_pkg::NUM_W'(blf_pkg::PCT_MAX)) begin
            pct = blf_pkg::PCT_MAX;
        end else begin
            pct = quo[6:0];
        end
    end

    assign dev  = (r_rdata > r_mean) ? r_rdata - r_mean : r_mean - r_rdata;
    assign term = (i_cmd.pass2 && dev >= i_outlier_limit) ? r_mean : r_rdata;

    always_comb begin
        priority if (r_chg) begin
            cls = blf_pkg::CLS_CHARGING;
        end else if (r_level < blf_pkg::LVL_LOW) begin
            cls = blf_pkg::CLS_LOW;
        end else if (r_level < blf_pkg::LVL_MID) begin
            cls = blf_pkg::CLS_MID;
        end else begin
            cls = blf_pkg::CLS_HIGH;
        end
    end

    // burst buffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_sample) begin
            mem[r_cnt] <= pct;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[r_idx[BIDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_idx       <= '0;
            r_sum       <= '0;
            r_rd_v      <= 1'b0;
            r_use_hist  <= 1'b0;
            r_last      <= blf_pkg::LAST_RESET;
            r_out_valid <= 1'b0;
            for (int i = 0; i < HISTORY_LEN; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            r_rd_v <= i_cmd.rd;
            if (i_cmd.wr_sample) begin
                r_cnt <= (r_cnt == BIDX_W'(BURST_LEN - 1)) ? '0 : r_cnt + 1'b1;
            end
            priority if (i_cmd.wr_sample || i_cmd.mean_ld || i_cmd.hist_shift) begin
                r_idx <= '0;
                r_sum <= '0;
            end else begin
                if (i_cmd.rd || i_cmd.hrot) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (r_rd_v) begin
                    r_sum <= r_sum + SUM_W'(term);
                end else if (i_cmd.hrot) begin
                    r_sum <= r_sum + SUM_W'(r_hist[HISTORY_LEN-1]);
                end
            end
            // shift the new mean in, or rotate once per summing step
            if (i_cmd.hist_shift) begin
                r_use_hist <= r_hist[HISTORY_LEN-2] != '0;
                r_hist[0]  <= r_mean;
                for (int i = 1; i < HISTORY_LEN; i++) begin
                    r_hist[i] <= r_hist[i-1];
                end
            end else if (i_cmd.hrot) begin
                r_hist[0] <= r_hist[HISTORY_LEN-1];
                for (int i = 1; i < HISTORY_LEN; i++) begin
                    r_hist[i] <= r_hist[i-1];
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_last      <= r_level;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_v   <= 15'(i_in_data.raw_sample) * 15'd5;
            r_chg <= i_in_data.charging;
        end
        if (i_cmd.mean_ld) begin
            r_mean <= avg;
        end
        if (i_cmd.level_ld) begin
            r_level <= r_use_hist ? avg : r_mean;
        end
        if (i_cmd.emit) begin
            r_out.level_percent <= r_level;
            r_out.level_changed <= r_level != r_last;
            r_out.level_class   <= cls;
        end
    end

    assign o_sts.div_done   = div_done;
    assign o_sts.burst_last = r_cnt == BIDX_W'(BURST_LEN - 1);
    assign o_sts.idx_last   = r_idx == IDX_W'(BURST_LEN - 1);
    assign o_sts.hidx_last  = r_idx == IDX_W'(HISTORY_LEN - 1);
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### src/blf_ctrl.sv
module blf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  blf_pkg::t_sts i_sts,
    output blf_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_PDIV_GO   = 4'd1;
    localparam logic [3:0] S_PDIV_WAIT = 4'd2;
    localparam logic [3:0] S_P1        = 4'd3;
    localparam logic [3:0] S_P1_END    = 4'd4;
    localparam logic [3:0] S_M1        = 4'd5;
    localparam logic [3:0] S_P2        = 4'd6;
    localparam logic [3:0] S_P2_END    = 4'd7;
    localparam logic [3:0] S_M2        = 4'd8;
    localparam logic [3:0] S_HSHIFT    = 4'd9;
    localparam logic [3:0] S_HSUM      = 4'd10;
    localparam logic [3:0] S_HMEAN     = 4'd11;
    localparam logic [3:0] S_EMIT      = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       in_take;

    assign o_in_stall = r_state != S_IDLE;
    assign in_take    = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_PDIV_GO;
                end
            end
            S_PDIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_PDIV_WAIT;
            end
            S_PDIV_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.wr_sample = 1'b1;
                    n_state         = i_sts.burst_last ? S_P1 : S_IDLE;
                end
            end
            S_P1: begin
                o_cmd.rd = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_P1_END;
                end
            end
            S_P1_END: begin
                n_state = S_M1;
            end
            S_M1: begin
                o_cmd.div_sel = blf_pkg::SEL_BURST;
                o_cmd.mean_ld = 1'b1;
                n_state       = S_P2;
            end
            S_P2: begin
                o_cmd.rd    = 1'b1;
                o_cmd.pass2 = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_P2_END;
                end
            end
            S_P2_END: begin
                o_cmd.pass2 = 1'b1;
                n_state     = S_M2;
            end
            S_M2: begin
                o_cmd.div_sel = blf_pkg::SEL_BURST;
                o_cmd.mean_ld = 1'b1;
                n_state       = S_HSHIFT;
            end
            S_HSHIFT: begin
                o_cmd.hist_shift = 1'b1;
                n_state          = S_HSUM;
            end
            S_HSUM: begin
                o_cmd.hrot = 1'b1;
                if (i_sts.hidx_last) begin
                    n_state = S_HMEAN;
                end
            end
            S_HMEAN: begin
                o_cmd.div_sel  = blf_pkg::SEL_HIST;
                o_cmd.level_ld = 1'b1;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                // hold until the output register can take the word
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_take_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_state == S_PDIV_GO)
        else $error("accepted word did not start the percent division");

    a_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> r_state == S_PDIV_WAIT)
        else $error("divider finished outside the wait state");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.out_free)
        else $error("result emitted over an untaken word");

endmodule

### src/battery_level_filter.sv
// Non-closing sample: the input stays stalled from accept until the 22-step
// restoring divider for the percent has finished and the sample is stored.
// Burst-closing sample: the stall also covers two walks over the burst buffer and
// one over the history; the means use a reciprocal multiply. Emitting also waits
// while the previous output word sits stalled.
// Reset (synchronous, active low) restores register defaults, empties the burst,
// clears the history and sets the last level to 101; no clearing pass.
module battery_level_filter #(
    parameter int BURST_LEN   = 10,
    parameter int HISTORY_LEN = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  blf_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output blf_pkg::t_out o_out_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [14:0]   r_adc_low;
    logic [14:0]   r_adc_high;
    logic [6:0]    r_outlier;
    logic [1:0]    reg_idx;
    blf_pkg::t_cmd cmd;
    blf_pkg::t_sts sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adc_low  <= blf_pkg::ADC_LOW_RST;
            r_adc_high <= blf_pkg::ADC_HIGH_RST;
            r_outlier  <= blf_pkg::OUTLIER_RST;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                blf_pkg::REG_ADC_LOW:  r_adc_low  <= pwdata[14:0];
                blf_pkg::REG_ADC_HIGH: r_adc_high <= pwdata[14:0];
                blf_pkg::REG_OUTLIER:  r_outlier  <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            blf_pkg::REG_ADC_LOW:  prdata = 32'(r_adc_low);
            blf_pkg::REG_ADC_HIGH: prdata = 32'(r_adc_high);
            blf_pkg::REG_OUTLIER:  prdata = 32'(r_outlier);
            default:               prdata = '0;
        endcase
    end

    blf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    blf_datapath #(
        .BURST_LEN   (BURST_LEN),
        .HISTORY_LEN (HISTORY_LEN)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_in_data       (i_in_data),
        .i_adc_low       (r_adc_low),
        .i_adc_high      (r_adc_high),
        .i_outlier_limit (r_outlier),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_data      (o_out_data)
    );

endmodule
